FILE: rtl/core/length_prefixed_frame_receiver_macros.svh
// Assertion macros for the length-prefixed frame receiver.
// Used by the top level; needs no other file.
`ifndef LENGTH_PREFIXED_FRAME_RECEIVER_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LPFR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define LPFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/lpfr_pkg.sv
// Shared types and constants of the length-prefixed frame receiver.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package lpfr_pkg;

	// Width of the length accumulator and the payload byte counter.
	localparam int COUNT_WIDTH = 16;
	localparam int BYTE_W      = 8;
	localparam int EVENT_W     = 3;
	localparam int REPORT_W    = 16;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_IDX_W   = 1;
	localparam int IDLE_W      = 16;

	typedef logic [EVENT_W-1:0]     event_t;
	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;

	// Event codes.
	localparam event_t EV_HDR_BEGUN = 3'd0;
	localparam event_t EV_HDR_ENDED = 3'd1;
	localparam event_t EV_ABORTED   = 3'd2;
	localparam event_t EV_OVERSIZE  = 3'd3;
	localparam event_t EV_READY     = 3'd4;
	localparam event_t EV_DATA      = 3'd5;
	localparam event_t EV_TIMEOUT   = 3'd6;
	localparam event_t EV_COMPLETE  = 3'd7;

	// Register indexes.
	localparam cfg_idx_t REG_SIZE_LIMIT    = 1'd0;
	localparam cfg_idx_t REG_TIMEOUT_TICKS = 1'd1;

	localparam logic [CFG_DATA_W-1:0] SIZE_LIMIT_RST    = 16'd4096;
	localparam logic [CFG_DATA_W-1:0] TIMEOUT_TICKS_RST = 16'd1000;

	// Request type codes.
	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// Header framing characters.
	localparam logic [BYTE_W-1:0] CHAR_OPEN  = 8'h3C;
	localparam logic [BYTE_W-1:0] CHAR_CLOSE = 8'h3E;
	localparam logic [BYTE_W-1:0] CHAR_ABORT = 8'h25;
	localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'd48;
	localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'd57;

	localparam count_t COUNT_MAX = {COUNT_WIDTH{1'b1}};
	localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};

endpackage

`default_nettype wire

FILE: rtl/core/lpfr_ifs.sv
// Valid/ready channel interfaces of the length-prefixed frame receiver:
// request channel, result channel and configuration write channel. Uses lpfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lpfr_item_if;
	logic                        valid;
	logic                        ready;
	logic                        req_type;
	logic [lpfr_pkg::BYTE_W-1:0] rx_byte;
	logic                        host_busy;

	modport source (output valid, req_type, rx_byte, host_busy, input ready);
	modport sink (input valid, req_type, rx_byte, host_busy, output ready);
endinterface

interface lpfr_result_if;
	logic                          valid;
	logic                          ready;
	lpfr_pkg::event_t              event_res;
	logic [lpfr_pkg::BYTE_W-1:0]   data_byte;
	logic [lpfr_pkg::REPORT_W-1:0] byte_count;
	logic                          last;

	modport source (output valid, event_res, data_byte, byte_count, last, input ready);
	modport sink (input valid, event_res, data_byte, byte_count, last, output ready);
endinterface

interface lpfr_cfg_if;
	logic                            valid;
	logic                            ready;
	lpfr_pkg::cfg_idx_t              index;
	logic [lpfr_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/length_prefixed_frame_receiver.sv
// Length-prefixed frame receiver.
// Channels over lpfr_ifs, that is: request in (item), result out (result),
// register writes (cfg). The block waits for a header such as "<123>", then
// passes on that many payload bytes and reports the frame's end. Each request
// is a serial byte or a timer tick; header-phase requests are ignored while
// host_busy is high. One request produces zero to three results; the last
// result of a request carries last = 1.
// A request is registered at acceptance in the request register and decoded
// from there; its results are loaded into the result register, which drives
// the result channel, once that register is free.
// Throughput: one request per cycle as long as each produces at most one
// result and the result channel does not stall; the result register holds
// all results of one request and sends one per cycle while result.ready is high.
// When the result channel stalls, the result register holds and the request
// register fills behind it; after that item.ready drops.
// Reset clears all frame state and loads size_limit = 4096 and
// timeout_ticks = 1000. Register writes are taken in any cycle (cfg.ready is
// always high) and are meant to be issued while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
`include "length_prefixed_frame_receiver_macros.svh"

module length_prefixed_frame_receiver (
	input  wire             clk,
	input  wire             arst_n,
	lpfr_item_if.sink       item,
	lpfr_result_if.source   result,
	lpfr_cfg_if.sink        cfg
);

	localparam int MULT_W = lpfr_pkg::COUNT_WIDTH + 4;

	// Configuration registers.
	logic [lpfr_pkg::CFG_DATA_W-1:0] size_limit_q;
	logic [lpfr_pkg::CFG_DATA_W-1:0] timeout_ticks_q;

	// Frame state.
	logic                          in_payload_q;
	lpfr_pkg::count_t              length_q;
	lpfr_pkg::count_t              rcv_count_q;
	logic [lpfr_pkg::IDLE_W-1:0]   idle_q;

	// Request register.
	logic                          valid_s1;
	logic                          req_type_s1;
	logic [lpfr_pkg::BYTE_W-1:0]   rx_byte_s1;
	logic                          host_busy_s1;

	// Result register: all results of one request.
	logic                          valid_s2;
	logic [1:0]                    nres_s2;
	lpfr_pkg::event_t              ev0_s2;
	lpfr_pkg::event_t              ev1_s2;
	lpfr_pkg::event_t              ev2_s2;
	logic [lpfr_pkg::BYTE_W-1:0]   data_s2;
	logic [lpfr_pkg::REPORT_W-1:0] count_s2;
	logic [1:0]                    idx_q;

	// Decode of the registered request.
	logic [1:0]                    nres;
	lpfr_pkg::event_t              ev0;
	lpfr_pkg::event_t              ev1;
	lpfr_pkg::event_t              ev2;
	logic [lpfr_pkg::BYTE_W-1:0]   data_d;
	lpfr_pkg::count_t              count_d;
	logic                          in_payload_d;
	lpfr_pkg::count_t              length_d;
	lpfr_pkg::count_t              rcv_count_d;
	logic [lpfr_pkg::IDLE_W-1:0]   idle_d;
	logic                          frame_end;

	logic [MULT_W-1:0]             digit_sum;
	lpfr_pkg::count_t              rcv_inc;
	logic [lpfr_pkg::IDLE_W-1:0]   idle_inc;
	logic                          is_digit;
	logic                          oversize;

	logic                          res_last;
	logic                          out_done;
	logic                          s2_free;
	logic                          adv_s1;

	// Handshake control.
	assign res_last = (idx_q == (nres_s2 - 2'd1));
	assign out_done = valid_s2 && result.ready && res_last;
	assign s2_free  = !valid_s2 || out_done;
	assign adv_s1   = valid_s1 && s2_free;
	assign item.ready = !valid_s1 || s2_free;
	assign cfg.ready  = 1'b1;

	// Arithmetic helpers.
	assign is_digit  = (rx_byte_s1 >= lpfr_pkg::CHAR_ZERO) &&
		(rx_byte_s1 <= lpfr_pkg::CHAR_NINE);
	// length * 10 + digit, as two shifted adds.
	assign digit_sum = ({4'd0, length_q} << 3) + ({4'd0, length_q} << 1) +
		MULT_W'(rx_byte_s1 - lpfr_pkg::CHAR_ZERO);
	assign rcv_inc   = (rcv_count_q == lpfr_pkg::COUNT_MAX) ? rcv_count_q :
		rcv_count_q + 1'b1;
	assign idle_inc  = (idle_q == lpfr_pkg::IDLE_MAX) ? idle_q : idle_q + 1'b1;
	assign oversize  = 32'(length_q) > 32'(size_limit_q);

	// Request decode: results and next frame state.
	always_comb begin
		nres         = 2'd0;
		ev0          = lpfr_pkg::EV_HDR_BEGUN;
		ev1          = lpfr_pkg::EV_HDR_BEGUN;
		ev2          = lpfr_pkg::EV_HDR_BEGUN;
		data_d       = '0;
		count_d      = '0;
		in_payload_d = in_payload_q;
		length_d     = length_q;
		rcv_count_d  = rcv_count_q;
		idle_d       = idle_q;
		frame_end    = 1'b0;
		if (!in_payload_q) begin
			// Header phase: busy host and ticks are ignored.
			if (!host_busy_s1 && req_type_s1 == lpfr_pkg::REQ_BYTE) begin
				if (rx_byte_s1 == lpfr_pkg::CHAR_OPEN) begin
					nres = 2'd1;
					ev0  = lpfr_pkg::EV_HDR_BEGUN;
				end else if (rx_byte_s1 == lpfr_pkg::CHAR_ABORT) begin
					nres     = 2'd1;
					ev0      = lpfr_pkg::EV_ABORTED;
					length_d = '0;
				end else if (rx_byte_s1 == lpfr_pkg::CHAR_CLOSE) begin
					nres = 2'd1;
					ev0  = lpfr_pkg::EV_HDR_ENDED;
					// A zero length stays in the header phase.
					if (length_q != '0) begin
						in_payload_d = 1'b1;
						rcv_count_d  = '0;
						idle_d       = '0;
						if (oversize) begin
							nres = 2'd3;
							ev1  = lpfr_pkg::EV_OVERSIZE;
							ev2  = lpfr_pkg::EV_READY;
						end else begin
							nres = 2'd2;
							ev1  = lpfr_pkg::EV_READY;
						end
					end
				end else if (is_digit) begin
					// The length saturates at its largest value.
					length_d = (digit_sum > MULT_W'(lpfr_pkg::COUNT_MAX)) ?
						lpfr_pkg::COUNT_MAX : digit_sum[lpfr_pkg::COUNT_WIDTH-1:0];
				end
			end
		end else if (req_type_s1 == lpfr_pkg::REQ_TICK) begin
			idle_d = idle_inc;
			if (idle_inc >= timeout_ticks_q) begin
				nres      = 2'd1;
				ev0       = lpfr_pkg::EV_TIMEOUT;
				count_d   = rcv_count_q;
				frame_end = 1'b1;
			end
		end else if (rx_byte_s1 == lpfr_pkg::CHAR_ABORT) begin
			nres      = 2'd1;
			ev0       = lpfr_pkg::EV_ABORTED;
			count_d   = rcv_count_q;
			frame_end = 1'b1;
		end else begin
			// Payload byte: passed on, and the frame completes at its length.
			idle_d      = '0;
			rcv_count_d = rcv_inc;
			nres        = 2'd1;
			ev0         = lpfr_pkg::EV_DATA;
			data_d      = rx_byte_s1;
			count_d     = rcv_inc;
			if (rcv_inc >= length_q) begin
				nres      = 2'd2;
				ev1       = lpfr_pkg::EV_COMPLETE;
				frame_end = 1'b1;
			end
		end
		if (frame_end) begin
			in_payload_d = 1'b0;
			length_d     = '0;
			rcv_count_d  = '0;
			idle_d       = '0;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_limit_q    <= lpfr_pkg::SIZE_LIMIT_RST;
			timeout_ticks_q <= lpfr_pkg::TIMEOUT_TICKS_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				lpfr_pkg::REG_SIZE_LIMIT:    size_limit_q    <= cfg.data;
				lpfr_pkg::REG_TIMEOUT_TICKS: timeout_ticks_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Frame state advances when the registered request is decoded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q <= 1'b0;
			length_q     <= '0;
			rcv_count_q  <= '0;
			idle_q       <= '0;
		end else if (adv_s1) begin
			in_payload_q <= in_payload_d;
			length_q     <= length_d;
			rcv_count_q  <= rcv_count_d;
			idle_q       <= idle_d;
		end
	end

	// Request register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			req_type_s1  <= item.req_type;
			rx_byte_s1   <= item.rx_byte;
			host_busy_s1 <= item.host_busy;
		end
	end

	// Result register and result index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			nres_s2  <= 2'd1;
			idx_q    <= 2'd0;
		end else if (adv_s1 && nres != 2'd0) begin
			valid_s2 <= 1'b1;
			nres_s2  <= nres;
			idx_q    <= 2'd0;
		end else if (out_done) begin
			valid_s2 <= 1'b0;
			idx_q    <= 2'd0;
		end else if (valid_s2 && result.ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && nres != 2'd0) begin
			ev0_s2   <= ev0;
			ev1_s2   <= ev1;
			ev2_s2   <= ev2;
			data_s2  <= data_d;
			count_s2 <= lpfr_pkg::REPORT_W'(count_d);
		end
	end

	// Result channel.
	always_comb begin
		unique case (idx_q)
			2'd0:    result.event_res = ev0_s2;
			2'd1:    result.event_res = ev1_s2;
			default: result.event_res = ev2_s2;
		endcase
	end

	// Only the first result of a request can be a data event.
	assign result.valid      = valid_s2;
	assign result.data_byte  = (idx_q == 2'd0) ? data_s2 : '0;
	assign result.byte_count = count_s2;
	assign result.last       = res_last;

	// A new set of results never overwrites one still being sent.
	`LPFR_ASSERT_SAME(a_no_overwrite, clk, arst_n, adv_s1 && nres != 2'd0, !valid_s2 || out_done, "result register overwritten before all results were sent")

	// In the payload phase the byte count stays below the announced length.
	`LPFR_ASSERT_SAME(a_count_below_len, clk, arst_n, in_payload_q, length_q != '0 && rcv_count_q < length_q, "payload byte count reached length without completing")

	// A frame end always returns to the header phase.
	`LPFR_ASSERT_NEXT(a_end_to_header, clk, arst_n, adv_s1 && frame_end, !in_payload_q && length_q == '0, "frame end did not return to header phase")

endmodule

`default_nettype wire

FILE: dv/tb_length_prefixed_frame_receiver.sv
`timescale 1ns / 1ps
// Self-checking testbench of the length-prefixed frame receiver.
// Drives lpfr_item_if and lpfr_cfg_if, checks lpfr_result_if against a frame model.
// Needs lpfr_pkg, lpfr_ifs and length_prefixed_frame_receiver.

module tb_length_prefixed_frame_receiver;
	import lpfr_pkg::*;

	localparam int DRAIN_CYCLES     = 8;
	localparam int LONG_HOLD        = 300;
	localparam int RANDOM_PER_PHASE = 100;
	localparam int MAX_REPORTS      = 200;
	localparam int IDLE_RUN         = 20;

	// One request on the input channel. When typed is set, the events listed
	// here are expected instead of the model's; unused event slots are not checked.
	typedef struct packed {
		logic              req_type;
		logic [BYTE_W-1:0] rx_byte;
		logic              host_busy;
		logic              typed;
		logic [1:0]        n_ev;
		event_t            ev0;
		event_t            ev1;
		event_t            ev2;
		count_t            cnt;
	} stim_row_t;

	typedef struct packed {
		event_t              event_res;
		logic [BYTE_W-1:0]   data_byte;
		logic [REPORT_W-1:0] byte_count;
		logic                last;
	} frame_event_t;

	logic clk = 1'b0;
	logic arst_n;

	lpfr_item_if   req_ch();
	lpfr_result_if evt_ch();
	lpfr_cfg_if    reg_ch();

	length_prefixed_frame_receiver i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (req_ch),
		.result (evt_ch),
		.cfg    (reg_ch)
	);

	always #5 clk = ~clk;

	// Frame model state and its copy of the registers.
	logic                  mdl_in_payload;
	count_t                mdl_length;
	count_t                mdl_rcvd;
	logic [IDLE_W-1:0]     mdl_idle;
	logic [CFG_DATA_W-1:0] mdl_size_limit;
	logic [CFG_DATA_W-1:0] mdl_timeout;

	frame_event_t expected_events[$];
	stim_row_t    requests_in_flight[$];

	int errors           = 0;
	int results_checked  = 0;
	int reqs_accepted    = 0;
	int effective_reqs   = 0;
	int long_holds_asked = 0;
	int burst_left       = 0;
	bit paced            = 1'b1;

	// Directed part. Events are typed in where they follow directly from the
	// framing rules; rows with typed = 0 go through the model.
	stim_row_t directed_rows [23] = '{
		// A tick in the header phase and a request from a busy host are dropped.
		'{REQ_TICK, 8'hFF, 1'b0, 1'b1, 2'd0, EV_HDR_BEGUN, EV_HDR_BEGUN, EV_HDR_BEGUN, 16'd0},
		'{REQ_BYTE, CHAR_OPEN, 1'b1, 1'b1, 2'd0, EV_HDR_BEGUN, EV_HDR_BEGUN, EV_HDR_BEGUN, 16'd0},
		'{REQ_BYTE, CHAR_OPEN, 1'b0, 1'b1, 2'd1, EV_HDR_BEGUN, EV_HDR_BEGUN, EV_HDR_BEGUN, 16'd0},
		// A letter is ignored; closing with no length ends the header without a frame.
		'{REQ_BYTE, 8'h41, 1'b0, 1'b1, 2'd0, EV_HDR_BEGUN, EV_HDR_BEGUN, EV_HDR_BEGUN, 16'd0},
		'{REQ_BYTE, CHAR_CLOSE, 1'b0, 1'b1, 2'd1, EV_HDR_ENDED, EV_HDR_ENDED, EV_HDR_ENDED, 16'd0},
		// An abort clears a partial length.
		'{REQ_BYTE, CHAR_ZERO + 8'd1, 1'b0, 1'b1, 2'd0, EV_HDR_BEGUN, EV_HDR_BEGUN, EV_HDR_BEGUN,
			16'd0},
		'{REQ_BYTE, CHAR_ABORT, 1'b0, 1'b1, 2'd1, EV_ABORTED, EV_ABORTED, EV_ABORTED, 16'd0},
		// Five nines saturate the length, which then exceeds the reset size limit.
		'{REQ_BYTE, CHAR_OPEN, 1'b0, 1'b1, 2'd1, EV_HDR_BEGUN, EV_HDR_BEGUN, EV_HDR_BEGUN, 16'd0},
		'{REQ_BYTE, CHAR_NINE, 1'b0, 1'b1, 2'd0, EV_HDR_BEGUN, EV_HDR_BEGUN, EV_HDR_BEGUN, 16'd0},
		'{REQ_BYTE, CHAR_NINE, 1'b0, 1'b1, 2'd0, EV_HDR_BEGUN, EV_HDR_BEGUN, EV_HDR_BEGUN, 16'd0},
		'{REQ_BYTE, CHAR_NINE, 1'b0, 1'b1, 2'd0, EV_HDR_BEGUN, EV_HDR_BEGUN, EV_HDR_BEGUN, 16'd0},
		'{REQ_BYTE, CHAR_NINE, 1'b0, 1'b1, 2'd0, EV_HDR_BEGUN, EV_HDR_BEGUN, EV_HDR_BEGUN, 16'd0},
		'{REQ_BYTE, CHAR_NINE, 1'b0, 1'b1, 2'd0, EV_HDR_BEGUN, EV_HDR_BEGUN, EV_HDR_BEGUN, 16'd0},
		'{REQ_BYTE, CHAR_CLOSE, 1'b0, 1'b1, 2'd3, EV_HDR_ENDED, EV_OVERSIZE, EV_READY, 16'd0},
		// In the payload the busy flag does not matter; an idle tick gives nothing.
		'{REQ_BYTE, 8'h00, 1'b1, 1'b0, 2'd0, EV_HDR_BEGUN, EV_HDR_BEGUN, EV_HDR_BEGUN, 16'd0},
		'{REQ_BYTE, 8'hFF, 1'b0, 1'b0, 2'd0, EV_HDR_BEGUN, EV_HDR_BEGUN, EV_HDR_BEGUN, 16'd0},
		'{REQ_TICK, 8'h00, 1'b0, 1'b0, 2'd0, EV_HDR_BEGUN, EV_HDR_BEGUN, EV_HDR_BEGUN, 16'd0},
		'{REQ_BYTE, CHAR_ABORT, 1'b0, 1'b1, 2'd1, EV_ABORTED, EV_ABORTED, EV_ABORTED, 16'd2},
		// Length "02": framing characters inside the payload are plain data.
		'{REQ_BYTE, CHAR_ZERO, 1'b0, 1'b1, 2'd0, EV_HDR_BEGUN, EV_HDR_BEGUN, EV_HDR_BEGUN, 16'd0},
		'{REQ_BYTE, CHAR_ZERO + 8'd2, 1'b0, 1'b1, 2'd0, EV_HDR_BEGUN, EV_HDR_BEGUN, EV_HDR_BEGUN,
			16'd0},
		'{REQ_BYTE, CHAR_CLOSE, 1'b0, 1'b1, 2'd2, EV_HDR_ENDED, EV_READY, EV_READY, 16'd0},
		'{REQ_BYTE, CHAR_OPEN, 1'b1, 1'b0, 2'd0, EV_HDR_BEGUN, EV_HDR_BEGUN, EV_HDR_BEGUN, 16'd0},
		'{REQ_BYTE, CHAR_CLOSE, 1'b0, 1'b0, 2'd0, EV_HDR_BEGUN, EV_HDR_BEGUN, EV_HDR_BEGUN, 16'd0}
	};

	function automatic frame_event_t mk_event(input event_t ev, input logic [BYTE_W-1:0] b,
			input count_t c);
		frame_event_t e;
		e.event_res  = ev;
		e.data_byte  = b;
		e.byte_count = c;
		e.last       = 1'b0;
		return e;
	endfunction

	function automatic stim_row_t mk_req(input logic kind, input logic [BYTE_W-1:0] b,
			input logic busy);
		stim_row_t r;
		r           = '0;
		r.req_type  = kind;
		r.rx_byte   = b;
		r.host_busy = busy;
		return r;
	endfunction

	function automatic logic host_busy_draw();
		return ($urandom_range(0, 15) == 0);
	endfunction

	function automatic void mdl_back_to_header();
		mdl_in_payload = 1'b0;
		mdl_length     = '0;
		mdl_rcvd       = '0;
		mdl_idle       = '0;
	endfunction

	// Advances the frame model by one accepted request and queues the events
	// it causes, unless the row carries its own typed expectation. acted tells
	// whether the request did anything at all.
	task automatic receiver_step(input stim_row_t r, output int n, output bit acted);
		frame_event_t evs [3];
		logic [31:0]  grown;
		n     = 0;
		acted = 1'b1;
		if (!mdl_in_payload) begin
			if (r.host_busy || r.req_type == REQ_TICK) begin
				acted = 1'b0;
			end else if (r.rx_byte == CHAR_OPEN) begin
				evs[n] = mk_event(EV_HDR_BEGUN, '0, '0);
				n++;
			end else if (r.rx_byte == CHAR_ABORT) begin
				mdl_length = '0;
				evs[n] = mk_event(EV_ABORTED, '0, '0);
				n++;
			end else if (r.rx_byte == CHAR_CLOSE) begin
				evs[n] = mk_event(EV_HDR_ENDED, '0, '0);
				n++;
				// A zero length stays in the header phase.
				if (mdl_length != '0) begin
					if (mdl_length > mdl_size_limit) begin
						evs[n] = mk_event(EV_OVERSIZE, '0, '0);
						n++;
					end
					evs[n] = mk_event(EV_READY, '0, '0);
					n++;
					mdl_in_payload = 1'b1;
					mdl_rcvd       = '0;
					mdl_idle       = '0;
				end
			end else if (r.rx_byte >= CHAR_ZERO && r.rx_byte <= CHAR_NINE) begin
				// The announced length saturates instead of wrapping.
				grown = 32'(mdl_length) * 32'd10 + 32'(r.rx_byte - CHAR_ZERO);
				mdl_length = (grown > 32'(COUNT_MAX)) ? COUNT_MAX : count_t'(grown);
			end else begin
				acted = 1'b0;
			end
		end else if (r.req_type == REQ_TICK) begin
			// A timeout of zero behaves like one since the count is bumped first.
			if (mdl_idle != IDLE_MAX)
				mdl_idle++;
			if (mdl_idle >= mdl_timeout) begin
				evs[n] = mk_event(EV_TIMEOUT, '0, mdl_rcvd);
				n++;
				mdl_back_to_header();
			end
		end else if (r.rx_byte == CHAR_ABORT) begin
			evs[n] = mk_event(EV_ABORTED, '0, mdl_rcvd);
			n++;
			mdl_back_to_header();
		end else begin
			mdl_idle = '0;
			if (mdl_rcvd != COUNT_MAX)
				mdl_rcvd++;
			evs[n] = mk_event(EV_DATA, r.rx_byte, mdl_rcvd);
			n++;
			if (mdl_rcvd >= mdl_length) begin
				evs[n] = mk_event(EV_COMPLETE, '0, mdl_rcvd);
				n++;
				mdl_back_to_header();
			end
		end
		if (n > 0)
			evs[n-1].last = 1'b1;
		if (!r.typed)
			for (int i = 0; i < n; i++)
				expected_events.push_back(evs[i]);
	endtask

	// Every accepted request goes through the model at its acceptance edge.
	always @(posedge clk) begin : request_tracker
		stim_row_t    row;
		frame_event_t e;
		event_t       typed_ev;
		int           n;
		bit           acted;
		if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
			row = requests_in_flight.pop_front();
			receiver_step(row, n, acted);
			if (row.typed) begin
				for (int i = 0; i < row.n_ev; i++) begin
					typed_ev = (i == 0) ? row.ev0 : (i == 1) ? row.ev1 : row.ev2;
					e        = mk_event(typed_ev, '0, row.cnt);
					e.last   = (i == row.n_ev - 1);
					expected_events.push_back(e);
				end
			end
			reqs_accepted++;
			if (acted)
				effective_reqs++;
		end
	end

	// Each accepted event is compared with the oldest one still expected.
	always @(posedge clk) begin : event_checker
		frame_event_t got;
		frame_event_t want;
		if (evt_ch.valid === 1'b1 && evt_ch.ready === 1'b1) begin
			got = '{evt_ch.event_res, evt_ch.data_byte, evt_ch.byte_count, evt_ch.last};
			if (expected_events.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected event %0d byte %02h count %0d last %0b",
						$time, got.event_res, got.data_byte, got.byte_count, got.last);
			end else begin
				want = expected_events.pop_front();
				results_checked++;
				if (got.event_res !== want.event_res || got.data_byte !== want.data_byte ||
						got.byte_count !== want.byte_count || got.last !== want.last) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display({"%0t: mismatch, expected event %0d byte %02h count %0d last %0b,",
							" got event %0d byte %02h count %0d last %0b"}, $time,
							want.event_res, want.data_byte, want.byte_count, want.last,
							got.event_res, got.data_byte, got.byte_count, got.last);
				end
			end
		end
	end

	// Result side back-pressure. The pattern is drawn at random among
	// always ready, coin flips, a regular one-in-four stall and mostly stalled.
	// A long hold-off asked for by the stimulus takes precedence.
	initial begin : event_sink_pacer
		int cyc;
		int mode;
		int hold_left;
		int holds_done;
		cyc        = 0;
		mode       = 0;
		hold_left  = 0;
		holds_done = 0;
		evt_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 97 == 0)
				mode = $urandom_range(0, 3);
			if (holds_done != long_holds_asked) begin
				holds_done = long_holds_asked;
				hold_left  = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				evt_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0: evt_ch.ready <= 1'b1;
					1: evt_ch.ready <= $urandom_range(0, 1);
					2: evt_ch.ready <= (cyc % 4 != 0);
					default: evt_ch.ready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	// Offers one request and returns at the edge where it is accepted, with
	// valid left high. When paced, the sender goes quiet between bursts of random length.
	task automatic present_request(input stim_row_t row);
		int gap;
		if (paced && burst_left == 0) begin
			gap = $urandom_range(1, 8);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) :
				$urandom_range(1, 12);
		end
		if (burst_left > 0)
			burst_left--;
		requests_in_flight.push_back(row);
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= row.req_type;
		req_ch.rx_byte   <= row.rx_byte;
		req_ch.host_busy <= row.host_busy;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
	endtask

	// Stops sending, waits for every expected event, then lets the pipeline
	// settle in case the last requests produced nothing.
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes both registers back to back; only called while the block is idle.
	task automatic set_regs(input logic [CFG_DATA_W-1:0] limit,
			input logic [CFG_DATA_W-1:0] ticks);
		reg_ch.valid <= 1'b1;
		reg_ch.index <= REG_SIZE_LIMIT;
		reg_ch.data  <= limit;
		@(posedge clk);
		while (reg_ch.ready !== 1'b1)
			@(posedge clk);
		mdl_size_limit = limit;
		reg_ch.index <= REG_TIMEOUT_TICKS;
		reg_ch.data  <= ticks;
		@(posedge clk);
		while (reg_ch.ready !== 1'b1)
			@(posedge clk);
		mdl_timeout = ticks;
		reg_ch.valid <= 1'b0;
	endtask

	// One random frame: mostly a well-formed header and payload with random
	// content, sometimes cut short by an abort or an idle timeout, now and
	// then plain noise.
	task automatic send_frame();
		int                len;
		int                ending;
		int                sent;
		string             digits;
		logic [BYTE_W-1:0] b;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 6))
				present_request(mk_req($urandom_range(0, 1), $urandom_range(0, 255),
					$urandom_range(0, 1)));
			return;
		end
		present_request(mk_req(REQ_BYTE, CHAR_OPEN, host_busy_draw()));
		case ($urandom_range(0, 19))
			0: len = 0;
			1: len = $urandom_range(65536, 999999);
			2: len = $urandom_range(100, 65535);
			default: len = $urandom_range(1, 12);
		endcase
		digits = $sformatf("%0d", len);
		if ($urandom_range(0, 4) == 0)
			digits = {"0", digits};
		for (int i = 0; i < digits.len(); i++) begin
			// Header ticks and letters must leave the length alone.
			if ($urandom_range(0, 9) == 0)
				present_request(mk_req(REQ_TICK, $urandom_range(0, 255), 1'b0));
			if ($urandom_range(0, 14) == 0)
				present_request(mk_req(REQ_BYTE, $urandom_range(8'h41, 8'h7A), 1'b0));
			present_request(mk_req(REQ_BYTE, digits[i], host_busy_draw()));
		end
		if ($urandom_range(0, 11) == 0) begin
			present_request(mk_req(REQ_BYTE, CHAR_ABORT, 1'b0));
			return;
		end
		present_request(mk_req(REQ_BYTE, CHAR_CLOSE, host_busy_draw()));
		if (len == 0)
			return;
		// Endings 0 and 1 cut the frame short; long frames are always cut.
		ending = $urandom_range(0, 9);
		if (len > 64 && ending > 1)
			ending = $urandom_range(0, 1);
		sent = (ending <= 1) ? $urandom_range(0, (len > 10) ? 10 : len - 1) : len;
		for (int k = 0; k < sent; k++) begin
			if ($urandom_range(0, 5) == 0)
				repeat ($urandom_range(1, 2))
					present_request(mk_req(REQ_TICK, $urandom_range(0, 255),
						$urandom_range(0, 1)));
			b = $urandom_range(0, 255);
			present_request(mk_req(REQ_BYTE, b, $urandom_range(0, 1)));
		end
		if (ending == 1 && mdl_timeout <= 200) begin
			repeat ((mdl_timeout == 0) ? 1 : mdl_timeout)
				present_request(mk_req(REQ_TICK, $urandom_range(0, 255), $urandom_range(0, 1)));
		end else if (ending <= 1) begin
			present_request(mk_req(REQ_BYTE, CHAR_ABORT, $urandom_range(0, 1)));
		end
		// Once in a while the sender waits until all events are out.
		if ($urandom_range(0, 11) == 0)
			drain();
	endtask

	task automatic run_random_phase();
		int goal;
		goal = effective_reqs + RANDOM_PER_PHASE;
		while (effective_reqs < goal)
			send_frame();
		drain();
	endtask

	initial begin : stimulus
		req_ch.valid     = 1'b0;
		req_ch.req_type  = REQ_BYTE;
		req_ch.rx_byte   = '0;
		req_ch.host_busy = 1'b0;
		reg_ch.valid     = 1'b0;
		reg_ch.index     = REG_SIZE_LIMIT;
		reg_ch.data      = '0;
		arst_n           = 1'b0;
		mdl_size_limit   = SIZE_LIMIT_RST;
		mdl_timeout      = TIMEOUT_TICKS_RST;
		mdl_back_to_header();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows with the register values after reset.
		foreach (directed_rows[i])
			present_request(directed_rows[i]);
		drain();

		// Size limit and timeout of one; the result side starts with a long
		// hold-off so that the block backs up into the request channel.
		set_regs(16'd1, 16'd1);
		long_holds_asked++;
		run_random_phase();

		// Largest size limit with a zero timeout: the first idle tick ends a frame.
		set_regs(COUNT_MAX, 16'd0);
		run_random_phase();

		// Largest timeout: a back-to-back run of idle ticks far short of it
		// leaves the frame open until an abort ends it.
		set_regs(16'hFFFF, 16'hFFFF);
		present_request(mk_req(REQ_BYTE, CHAR_OPEN, 1'b0));
		present_request(mk_req(REQ_BYTE, CHAR_ZERO + 8'd3, 1'b0));
		present_request(mk_req(REQ_BYTE, CHAR_CLOSE, 1'b0));
		present_request(mk_req(REQ_BYTE, 8'hA5, 1'b0));
		paced = 1'b0;
		repeat (IDLE_RUN)
			present_request(mk_req(REQ_TICK, $urandom_range(0, 255), $urandom_range(0, 1)));
		paced = 1'b1;
		present_request(mk_req(REQ_BYTE, CHAR_ABORT, 1'b0));
		run_random_phase();

		// Small random settings so that oversize and timeouts are common.
		set_regs($urandom_range(1, 40), $urandom_range(2, 30));
		long_holds_asked++;
		run_random_phase();

		$display("Ran %0d requests (%0d of them effective) and checked %0d events",
			reqs_accepted, effective_reqs, results_checked);
		$display("over five register settings, including both register extremes.");
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/lpfr_pkg.sv
rtl/core/lpfr_ifs.sv
rtl/core/length_prefixed_frame_receiver.sv
dv/tb_length_prefixed_frame_receiver.sv
